### sv/cpfp_pkg.sv
// ----------------------------------------------------------------------------
// cpfp_pkg
// Shared types and constants of the count packet field parser.
// ----------------------------------------------------------------------------
package cpfp_pkg;

	localparam int          NUM_CH    = 7;
	localparam int          IDX_W     = 5;
	localparam int          CFG_IDX_W = 8;
	localparam int          CFG_DAT_W = 16;

	localparam logic [IDX_W-1:0] FRAME_LEN   = 5'd26;
	localparam logic [IDX_W-1:0] POS_ID_LO   = 5'd0;
	localparam logic [IDX_W-1:0] POS_ID_HI   = 5'd1;
	localparam logic [IDX_W-1:0] POS_CHAR_M  = 5'd2;
	localparam logic [IDX_W-1:0] POS_CHAR_U  = 5'd3;
	localparam logic [IDX_W-1:0] POS_VERSION = 5'd4;
	localparam logic [IDX_W-1:0] POS_SEQ     = 5'd5;
	localparam int               POS_EPOCH   = 6;
	localparam int               POS_COUNT   = 10;
	localparam logic [IDX_W-1:0] POS_STATUS  = 5'd24;
	localparam logic [IDX_W-1:0] POS_HV      = 5'd25;

	localparam logic [7:0]  CHAR_M         = 8'h4D;
	localparam logic [7:0]  CHAR_U         = 8'h55;
	localparam logic [15:0] MAKER_ID_RESET = 16'hFFFF;
	localparam logic [7:0]  VERSION_RESET  = 8'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAKER_ID = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 8'd1;

	typedef logic [NUM_CH-1:0][15:0] count_arr_t;

	typedef struct packed {
		logic        packet_ok;
		logic [7:0]  sequence_res;
		logic [31:0] epoch_seconds;
		count_arr_t  count;
		logic [7:0]  status_bits;
		logic [7:0]  hv_setting;
	} result_t;

endpackage

### sv/cpfp_parse.sv
// ----------------------------------------------------------------------------
// cpfp_parse
// Frame state: byte position, header check flag and captured fields. Builds
// the result for the item that carries the last-byte mark.
// ----------------------------------------------------------------------------
module cpfp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [15:0]         maker_id,
	input  logic [7:0]          version,
	output logic                res_valid,
	output cpfp_pkg::result_t   res
);

	logic [cpfp_pkg::IDX_W-1:0] byte_index_q;
	logic                       header_bad_q;
	logic [7:0]                 seq_q;
	logic [31:0]                epoch_q;
	cpfp_pkg::count_arr_t       count_q;
	logic [7:0]                 status_q;
	logic [7:0]                 hv_q;

	logic                       in_frame;
	logic [cpfp_pkg::IDX_W-1:0] idx_nxt;
	logic                       bad_nxt;
	logic [7:0]                 seq_nxt;
	logic [31:0]                epoch_nxt;
	cpfp_pkg::count_arr_t       count_nxt;
	logic [7:0]                 status_nxt;
	logic [7:0]                 hv_nxt;
	logic                       ok;

	always_comb begin
		in_frame   = byte_index_q < cpfp_pkg::FRAME_LEN;
		idx_nxt    = in_frame ? byte_index_q + 5'd1 : byte_index_q;
		bad_nxt    = header_bad_q;
		seq_nxt    = seq_q;
		epoch_nxt  = epoch_q;
		count_nxt  = count_q;
		status_nxt = status_q;
		hv_nxt     = hv_q;
		if (in_frame) begin
			if (byte_index_q == cpfp_pkg::POS_ID_LO && data_byte != maker_id[7:0])
				bad_nxt = 1'b1;
			if (byte_index_q == cpfp_pkg::POS_ID_HI && data_byte != maker_id[15:8])
				bad_nxt = 1'b1;
			if (byte_index_q == cpfp_pkg::POS_CHAR_M && data_byte != cpfp_pkg::CHAR_M)
				bad_nxt = 1'b1;
			if (byte_index_q == cpfp_pkg::POS_CHAR_U && data_byte != cpfp_pkg::CHAR_U)
				bad_nxt = 1'b1;
			if (byte_index_q == cpfp_pkg::POS_VERSION && data_byte != version)
				bad_nxt = 1'b1;
			if (byte_index_q == cpfp_pkg::POS_SEQ)
				seq_nxt = data_byte;
			for (int k = 0; k < 4; k++) begin
				if (byte_index_q == 5'(cpfp_pkg::POS_EPOCH + k))
					epoch_nxt[8*k +: 8] = data_byte;
			end
			for (int c = 0; c < cpfp_pkg::NUM_CH; c++) begin
				if (byte_index_q == 5'(cpfp_pkg::POS_COUNT + 2*c))
					count_nxt[c][7:0] = data_byte;
				if (byte_index_q == 5'(cpfp_pkg::POS_COUNT + 2*c + 1))
					count_nxt[c][15:8] = data_byte;
			end
			if (byte_index_q == cpfp_pkg::POS_STATUS)
				status_nxt = data_byte;
			if (byte_index_q == cpfp_pkg::POS_HV)
				hv_nxt = data_byte;
		end
	end

	assign ok = (idx_nxt >= cpfp_pkg::FRAME_LEN) && !bad_nxt;

	always_comb begin
		res_valid         = accept && last_byte;
		res.packet_ok     = ok;
		res.sequence_res  = ok ? seq_nxt : '0;
		res.epoch_seconds = ok ? epoch_nxt : '0;
		res.count         = ok ? count_nxt : '0;
		res.status_bits   = ok ? status_nxt : '0;
		res.hv_setting    = ok ? hv_nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			header_bad_q <= 1'b0;
			seq_q        <= '0;
			epoch_q      <= '0;
			count_q      <= '0;
			status_q     <= '0;
			hv_q         <= '0;
		end else if (accept) begin
			byte_index_q <= last_byte ? '0 : idx_nxt;
			header_bad_q <= last_byte ? 1'b0 : bad_nxt;
			seq_q        <= seq_nxt;
			epoch_q      <= epoch_nxt;
			count_q      <= count_nxt;
			status_q     <= status_nxt;
			hv_q         <= hv_nxt;
		end
	end

endmodule

### sv/cpfp_out_buf.sv
// ----------------------------------------------------------------------------
// cpfp_out_buf
// Result register with a skid entry, so the input keeps flowing while one
// result waits on a stalled output.
// ----------------------------------------------------------------------------
module cpfp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cpfp_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output cpfp_pkg::result_t out_data
);

	logic              out_valid_q;
	cpfp_pkg::result_t out_data_q;
	logic              skid_valid_q;
	cpfp_pkg::result_t skid_data_q;
	logic              pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

### sv/count_packet_field_parser_unit.sv
// ----------------------------------------------------------------------------
// count_packet_field_parser_unit
// Parses a 26-byte count frame from a manufacturer data field.
// ----------------------------------------------------------------------------
// One byte item is taken every cycle unless the input is stalled. Each byte
// is checked or captured at its position; the item marked as last byte yields
// one result. The output register plus one skid entry hold results; the input
// stalls only while both are full. The result reports packet_ok and, when it
// is set, the sequence, epoch, seven channel counts, status and high-voltage
// bytes (all zero otherwise). Register 0 is the expected maker id, register 1
// the expected version; other indexes are ignored. Configuration writes are
// always ready.
module count_packet_field_parser_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cpfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpfp_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                packet_ok,
	output logic [7:0]                          sequence_res,
	output logic [31:0]                         epoch_seconds,
	output logic [15:0]                         count_ch0,
	output logic [15:0]                         count_ch1,
	output logic [15:0]                         count_ch2,
	output logic [15:0]                         count_ch3,
	output logic [15:0]                         count_ch4,
	output logic [15:0]                         count_ch5,
	output logic [15:0]                         count_ch6,
	output logic [7:0]                          status_bits,
	output logic [7:0]                          hv_setting
);

	logic [15:0]       maker_id_q;
	logic [7:0]        version_q;
	logic              accept;
	logic              res_valid;
	cpfp_pkg::result_t res;
	cpfp_pkg::result_t out_data;
	logic              buf_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maker_id_q <= cpfp_pkg::MAKER_ID_RESET;
			version_q  <= cpfp_pkg::VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpfp_pkg::CFG_MAKER_ID: maker_id_q <= cfg_data;
				cpfp_pkg::CFG_VERSION:  version_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	cpfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.maker_id  (maker_id_q),
		.version   (version_q),
		.res_valid (res_valid),
		.res       (res)
	);

	cpfp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign packet_ok     = out_data.packet_ok;
	assign sequence_res  = out_data.sequence_res;
	assign epoch_seconds = out_data.epoch_seconds;
	assign count_ch0     = out_data.count[0];
	assign count_ch1     = out_data.count[1];
	assign count_ch2     = out_data.count[2];
	assign count_ch3     = out_data.count[3];
	assign count_ch4     = out_data.count[4];
	assign count_ch5     = out_data.count[5];
	assign count_ch6     = out_data.count[6];
	assign status_bits   = out_data.status_bits;
	assign hv_setting    = out_data.hv_setting;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_ok |-> sequence_res == 8'd0 && epoch_seconds == 32'd0
			&& count_ch0 == 16'd0 && count_ch6 == 16'd0
			&& status_bits == 8'd0 && hv_setting == 8'd0)
		else $error("rejected result carries nonzero fields");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid)
		else $error("result lost after last byte");

endmodule
